@@ rtl/llist_pkg.sv @@
// shared constants, types and codes for the linked list engine
package llist_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_AFTER = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_READ_OUT  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_PLACE,
    S_WALK,
    S_AFTER,
    S_DEL,
    S_RD,
    S_RDD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    logic re;
    idx_t raddr;
  } link_req_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    idx_t  raddr;
  } val_req_t;

endpackage

@@ rtl/llist_ram.sv @@
// generic single-write single-read ram with registered read data
module llist_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/llist_ctrl.sv @@
// list sequencer: head, tail, free list, allocation, link walk and result register
module llist_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_mode,
  input  llist_pkg::data_t    in_value,
  input  logic [4:0]          in_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output llist_pkg::data_t    out_value_res,
  output logic                out_last,
  output llist_pkg::link_req_t link_req,
  input  llist_pkg::idx_t     link_rdata,
  output llist_pkg::val_req_t val_req,
  input  llist_pkg::data_t    val_rdata
);
  import llist_pkg::*;

  state_t  state_r, state_nxt;
  idx_t    head_r, head_nxt;
  idx_t    tail_r, tail_nxt;
  idx_t    free_r, free_nxt;
  cnt_t    fresh_r, fresh_nxt;
  cnt_t    count_r, count_nxt;
  logic    out_valid_r, out_valid_nxt;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  data_t   val_r, val_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  idx_t    cur_r, cur_nxt;
  idx_t    ent_r, ent_nxt;
  cnt_t    steps_r, steps_nxt;
  status_t stat_r, stat_nxt;
  status_t out_status_r, out_status_nxt;
  data_t   out_value_r, out_value_nxt;
  logic    out_last_r, out_last_nxt;

  logic    out_free;
  logic    is_full;
  logic    bad_pos;

  assign out_free = !out_valid_r || out_ready;
  assign is_full  = (count_r >= cnt_t'(CAPACITY));
  assign bad_pos  = (CMP_W'(pos_r) >= CMP_W'(count_r));

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    mode_nxt       = mode_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    ent_nxt        = ent_r;
    steps_nxt      = steps_r;
    stat_nxt       = stat_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    link_req       = '0;
    val_req        = '0;
    in_ready       = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          val_nxt   = in_value;
          pos_nxt   = in_position;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (mode_r)
          MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AFTER: begin
            if (is_full) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else if (mode_r == MODE_INS_AFTER && bad_pos) begin
              stat_nxt  = ST_BADPOS;
              state_nxt = S_RESP;
            end else if (fresh_r > count_r) begin
              link_req.re    = 1'b1;
              link_req.raddr = free_r;
              ent_nxt        = free_r;
              state_nxt      = S_ALLOC;
            end else begin
              ent_nxt   = fresh_r[IDX_W-1:0];
              fresh_nxt = fresh_r + cnt_t'(1);
              state_nxt = S_PLACE;
            end
          end
          MODE_DEL_FRONT: begin
            if (count_r == '0) begin
              stat_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              link_req.re    = 1'b1;
              link_req.raddr = head_r;
              state_nxt      = S_DEL;
            end
          end
          MODE_READ_OUT: begin
            if (count_r == '0) begin
              stat_nxt  = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              cur_nxt   = head_r;
              steps_nxt = count_r - cnt_t'(1);
              state_nxt = S_RD;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        free_nxt  = link_rdata;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        unique case (mode_r)
          MODE_INS_FRONT: begin
            val_req.we     = 1'b1;
            val_req.waddr  = ent_r;
            val_req.wdata  = val_r;
            link_req.we    = 1'b1;
            link_req.waddr = ent_r;
            link_req.wdata = head_r;
            head_nxt       = ent_r;
            if (count_r == '0) begin
              tail_nxt = ent_r;
            end
            count_nxt = count_r + cnt_t'(1);
            stat_nxt  = ST_OK;
            state_nxt = S_RESP;
          end
          MODE_INS_BACK: begin
            val_req.we    = 1'b1;
            val_req.waddr = ent_r;
            val_req.wdata = val_r;
            if (count_r == '0) begin
              head_nxt = ent_r;
            end else begin
              link_req.we    = 1'b1;
              link_req.waddr = tail_r;
              link_req.wdata = ent_r;
            end
            tail_nxt  = ent_r;
            count_nxt = count_r + cnt_t'(1);
            stat_nxt  = ST_OK;
            state_nxt = S_RESP;
          end
          MODE_INS_AFTER: begin
            link_req.re    = 1'b1;
            link_req.raddr = head_r;
            cur_nxt        = head_r;
            steps_nxt      = cnt_t'(pos_r);
            state_nxt      = S_WALK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        if (steps_r == '0) begin
          link_req.we    = 1'b1;
          link_req.waddr = ent_r;
          link_req.wdata = link_rdata;
          state_nxt      = S_AFTER;
        end else begin
          link_req.re    = 1'b1;
          link_req.raddr = link_rdata;
          cur_nxt        = link_rdata;
          steps_nxt      = steps_r - cnt_t'(1);
        end
      end
      S_AFTER: begin
        link_req.we    = 1'b1;
        link_req.waddr = cur_r;
        link_req.wdata = ent_r;
        val_req.we     = 1'b1;
        val_req.waddr  = ent_r;
        val_req.wdata  = val_r;
        if (cur_r == tail_r) begin
          tail_nxt = ent_r;
        end
        count_nxt = count_r + cnt_t'(1);
        stat_nxt  = ST_OK;
        state_nxt = S_RESP;
      end
      S_DEL: begin
        head_nxt       = link_rdata;
        link_req.we    = 1'b1;
        link_req.waddr = head_r;
        link_req.wdata = free_r;
        free_nxt       = head_r;
        count_nxt      = count_r - cnt_t'(1);
        stat_nxt       = ST_OK;
        state_nxt      = S_RESP;
      end
      S_RD: begin
        link_req.re    = 1'b1;
        link_req.raddr = cur_r;
        val_req.re     = 1'b1;
        val_req.raddr  = cur_r;
        state_nxt      = S_RDD;
      end
      S_RDD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = val_rdata;
          out_last_nxt   = (steps_r == '0);
          if (steps_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            link_req.re    = 1'b1;
            link_req.raddr = link_rdata;
            val_req.re     = 1'b1;
            val_req.raddr  = link_rdata;
            steps_nxt      = steps_r - cnt_t'(1);
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      fresh_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    ent_r        <= ent_nxt;
    steps_r      <= steps_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_res = out_value_r;
  assign out_last      = out_last_r;

endmodule

@@ rtl/linked_list_engine.sv @@
// top level of the linked list engine: sequencer plus link and value memories
//
// requests arrive on the in_ channel (valid/ready): in_mode selects insert
// front, insert back, insert after in_position, delete front or read out.
// mode codes five to seven are dropped and give no beat.
// every other request answers on the out_ channel (valid/ready) with out_status;
// a non-empty read out gives one beat per element in list order, with
// out_last on the final one, otherwise a single beat with out_last set.
// a read out gives one element per cycle while the receiver takes each
// beat; each link step is one read of the link memory, whose read data
// is registered.
// one request is in flight at a time; a new request is taken as soon as the
// sequencer is idle, even while the last result still waits in the output
// register. a stalled receiver holds the output register and pauses the walk.
// reset empties the list at once; no memory clearing pass is needed.
module linked_list_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_mode,
  input  llist_pkg::data_t in_value,
  input  logic [4:0]       in_position,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output llist_pkg::data_t out_value_res,
  output logic             out_last
);
  import llist_pkg::*;

  link_req_t link_req;
  val_req_t  val_req;
  idx_t      link_rdata;
  data_t     val_rdata;

  llist_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_res (out_value_res),
    .out_last      (out_last),
    .link_req      (link_req),
    .link_rdata    (link_rdata),
    .val_req       (val_req),
    .val_rdata     (val_rdata)
  );

  llist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (IDX_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .re    (link_req.re),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  llist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_req.we),
    .waddr (val_req.waddr),
    .wdata (val_req.wdata),
    .re    (val_req.re),
    .raddr (val_req.raddr),
    .rdata (val_rdata)
  );

endmodule

@@ rtl/llist_chk.sv @@
// port-level checks for the linked list engine, bound to the top level
module llist_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_status,
  input llist_pkg::data_t out_value_res,
  input logic             out_last
);
  import llist_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_value_res) && $stable(out_last))
    else $error("result beat changed while stalled");

  // error answers are single beats
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_value_res == '0)
    else $error("error status without last or with data");

  // a non-final beat only comes from a read out
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("non-final beat with error status");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind linked_list_engine llist_chk u_llist_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_value_res (out_value_res),
  .out_last      (out_last)
);

@@ tb/llist_checker.sv @@
// checker for the linked list engine: predicts reply beats from accepted requests and compares
module llist_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [2:0]       in_mode,
  input  llist_pkg::data_t in_value,
  input  logic [4:0]       in_position,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       out_status,
  input  llist_pkg::data_t out_value_res,
  input  logic             out_last,
  output int               fail_count,
  output int               reply_backlog
);
  import llist_pkg::*;

  typedef struct packed {
    status_t status;
    data_t   value;
    logic    last;
  } reply_t;

  data_t  node_value [CAPACITY];
  idx_t   node_link  [CAPACITY];
  idx_t   head_idx;
  idx_t   tail_idx;
  idx_t   free_idx;
  cnt_t   fresh_cnt;
  cnt_t   length;
  reply_t list_replies [$];
  int     beat_no;

  function automatic void push_reply(status_t s, data_t v, logic l);
    reply_t r;
    r.status = s;
    r.value  = v;
    r.last   = l;
    list_replies.push_back(r);
  endfunction

  // free list first, then a never used node
  function automatic idx_t take_node();
    idx_t e;
    if (fresh_cnt > length) begin
      e = free_idx;
      free_idx = node_link[e];
    end else begin
      e = fresh_cnt[IDX_W-1:0];
      fresh_cnt++;
    end
    return e;
  endfunction

  function automatic void apply_list_op(logic [2:0] m, data_t v, logic [4:0] p);
    idx_t e;
    idx_t t;
    unique case (m)
      MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AFTER: begin
        if (length >= CAPACITY) begin
          push_reply(ST_FULL, '0, 1'b1);
        end else if (m == MODE_INS_AFTER && p >= length) begin
          push_reply(ST_BADPOS, '0, 1'b1);
        end else begin
          e = take_node();
          node_value[e] = v;
          if (m == MODE_INS_FRONT) begin
            node_link[e] = head_idx;
            head_idx = e;
            if (length == 0) tail_idx = e;
          end else if (m == MODE_INS_BACK) begin
            node_link[e] = '0;
            if (length == 0) head_idx = e;
            else node_link[tail_idx] = e;
            tail_idx = e;
          end else begin
            t = head_idx;
            for (int i = 0; i < p; i++) t = node_link[t];
            node_link[e] = node_link[t];
            node_link[t] = e;
            if (t == tail_idx) tail_idx = e;
          end
          length++;
          push_reply(ST_OK, '0, 1'b1);
        end
      end
      MODE_DEL_FRONT: begin
        if (length == 0) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          e = head_idx;
          head_idx = node_link[e];
          node_link[e] = free_idx;
          free_idx = e;
          length--;
          push_reply(ST_OK, '0, 1'b1);
        end
      end
      MODE_READ_OUT: begin
        if (length == 0) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          t = head_idx;
          for (int i = 0; i < length; i++) begin
            push_reply(ST_OK, node_value[t], (i + 1 == length));
            t = node_link[t];
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      head_idx  = '0;
      tail_idx  = '0;
      free_idx  = '0;
      fresh_cnt = '0;
      length    = '0;
      beat_no   = 0;
      list_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (list_replies.size() == 0) begin
          if (fail_count < 10)
            $display("beat %0d: unexpected reply status %0d value %0d last %0b",
                     beat_no, out_status, out_value_res, out_last);
          fail_count++;
        end else begin
          want = list_replies.pop_front();
          if (out_status !== want.status || out_value_res !== want.value ||
              out_last !== want.last) begin
            if (fail_count < 10)
              $display("beat %0d: expected status %0d value %0d last %0b, got %0d %0d %0b",
                       beat_no, want.status, want.value, want.last,
                       out_status, out_value_res, out_last);
            fail_count++;
          end
        end
        beat_no++;
      end
      if (in_valid && in_ready) apply_list_op(in_mode, in_value, in_position);
    end
    reply_backlog <= list_replies.size();
  end

endmodule

@@ tb/tb_linked_list_engine.sv @@
// testbench top for the linked list engine: clock, reset, request stimulus and verdict
module tb_linked_list_engine;
  import llist_pkg::*;

  localparam logic [2:0] FIRST_UNUSED_MODE = 3'd5;
  localparam logic [2:0] LAST_UNUSED_MODE  = 3'd7;
  localparam int         ITEM_TARGET       = 450;
  localparam int         HOLD_CYCLES       = 400;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [2:0] in_mode       = '0;
  data_t      in_value      = '0;
  logic [4:0] in_position   = '0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [1:0] out_status;
  data_t      out_value_res;
  logic       out_last;

  int   fail_count;
  int   reply_backlog;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   hold_left  = 0;
  logic hold_req   = 1'b0;
  logic hold_done  = 1'b0;
  int   list_len   = 0;
  int   items_sent = 0;

  linked_list_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_res (out_value_res),
    .out_last      (out_last)
  );

  llist_checker list_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_res (out_value_res),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .reply_backlog (reply_backlog)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic issue_request(input logic [2:0] m, input data_t v, input logic [4:0] p);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= m;
    in_value    <= v;
    in_position <= p;
    do @(posedge clk); while (!in_ready);
    case (m)
      MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AFTER:
        if (list_len < CAPACITY && (m != MODE_INS_AFTER || p < list_len)) list_len++;
      MODE_DEL_FRONT:
        if (list_len > 0) list_len--;
      default: ;
    endcase
    if (m <= MODE_READ_OUT) items_sent++;
  endtask

  task automatic fill_and_drain(input bit with_hold);
    logic [2:0] m;
    while (list_len < CAPACITY) begin
      m = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_AFTER));
      issue_request(m, data_t'($urandom),
                    (list_len == 0) ? 5'($urandom) : 5'($urandom_range(0, list_len - 1)));
    end
    // insert after the last position on a full list is refused as full
    issue_request(MODE_INS_AFTER, data_t'($urandom), 5'd31);
    issue_request(MODE_INS_BACK, data_t'($urandom), 5'($urandom));
    if (with_hold) hold_req <= 1'b1;
    issue_request(MODE_READ_OUT, data_t'($urandom), 5'($urandom));
    issue_request(MODE_READ_OUT, data_t'($urandom), 5'($urandom));
    while (list_len > 0) begin
      if ($urandom_range(0, 9) == 0)
        issue_request(MODE_READ_OUT, data_t'($urandom), 5'($urandom));
      else
        issue_request(MODE_DEL_FRONT, data_t'($urandom), 5'($urandom));
    end
    issue_request(MODE_DEL_FRONT, data_t'($urandom), 5'($urandom));
  endtask

  initial begin
    int         r;
    bit         growing;
    logic [2:0] m;
    logic [4:0] p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty list corners, then short list, bad position and unused mode corners
    issue_request(MODE_READ_OUT, 32'sd0, 5'd0);
    issue_request(MODE_DEL_FRONT, 32'sd0, 5'd0);
    issue_request(MODE_INS_AFTER, 32'sd5, 5'd0);
    issue_request(MODE_INS_FRONT, 32'sh7fffffff, 5'd31);
    issue_request(MODE_INS_BACK, 32'sh80000000, 5'd0);
    issue_request(MODE_INS_AFTER, -32'sd1, 5'd1);
    issue_request(MODE_INS_AFTER, 32'sd0, 5'd0);
    issue_request(MODE_INS_FRONT, 32'sd1, 5'd0);
    issue_request(MODE_READ_OUT, 32'sd0, 5'd0);
    issue_request(MODE_INS_AFTER, 32'sd12345, 5'd4);
    issue_request(MODE_INS_AFTER, 32'sd7, 5'd6);
    issue_request(MODE_INS_AFTER, 32'sd9, 5'd31);
    issue_request(MODE_DEL_FRONT, 32'sd0, 5'd0);
    issue_request(MODE_DEL_FRONT, 32'sd0, 5'd0);
    issue_request(MODE_INS_BACK, -32'sd77, 5'd0);
    issue_request(MODE_INS_FRONT, 32'sd88, 5'd0);
    issue_request(FIRST_UNUSED_MODE, 32'sd3, 5'd3);
    issue_request(FIRST_UNUSED_MODE + 3'd1, 32'sh7fffffff, 5'd31);
    issue_request(LAST_UNUSED_MODE, 32'sh80000000, 5'd0);
    issue_request(MODE_READ_OUT, 32'sd0, 5'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 75; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 75; end
        default: begin idle_pct = 7; stall_pct <= 7; end
      endcase
      if (ph == 0 || ph == 2) fill_and_drain(ph == 0);
      while (items_sent < ITEM_TARGET * (ph + 1) / 4) begin
        growing = ((items_sent / 30) % 2) == 0;
        r = $urandom_range(0, 99);
        if (r < 5) begin
          issue_request(3'($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE)),
                        data_t'($urandom), 5'($urandom));
        end else if (r < 17) begin
          issue_request(MODE_READ_OUT, data_t'($urandom), 5'($urandom));
        end else if (r < (growing ? 75 : 42)) begin
          m = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_AFTER));
          if (m == MODE_INS_AFTER && list_len > 0 && $urandom_range(0, 99) < 85)
            p = 5'($urandom_range(0, list_len - 1));
          else
            p = 5'($urandom);
          issue_request(m, data_t'($urandom), p);
        end else begin
          issue_request(MODE_DEL_FRONT, data_t'($urandom), 5'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (reply_backlog != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && reply_backlog == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #12000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/llist_pkg.sv
rtl/llist_ram.sv
rtl/llist_ctrl.sv
rtl/linked_list_engine.sv
rtl/llist_chk.sv
tb/llist_checker.sv
tb/tb_linked_list_engine.sv
